// File: src/rms_error_accumulator_defines.svh
// Assertion macros shared by the rms error accumulator modules
`ifndef RMS_ERROR_ACCUMULATOR_DEFINES_SVH
`define RMS_ERROR_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define RMSE_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define RMSE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define RMSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RMSE_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define RMSE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define RMSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: src/rmse_pkg.sv
// Shared constants and types of the rms error accumulator
package rmse_pkg;

   localparam int MAX_TRACE_LEN = 65536;
   localparam int MAX_TRACES    = 16;
   localparam int SAMPLE_BITS   = 16;

   localparam int FIELD_BITS   = 16;
   localparam int ERROR_BITS   = 16;
   localparam int TRACE_BITS   = 4;
   localparam int TOTAL_BITS   = 20;

   localparam int DIFF_BITS    = SAMPLE_BITS + 1;
   localparam int SQ_BITS      = 2 * SAMPLE_BITS + 1;
   localparam int SUM_BITS     = 48;
   localparam int COUNT_BITS   = $clog2(MAX_TRACE_LEN + 1);
   localparam int ROOT_BITS    = SUM_BITS / 2;
   localparam int STEP_BITS    = $clog2(SUM_BITS);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

   localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
   localparam logic [ERROR_BITS-1:0] ERROR_MAX = {ERROR_BITS{1'b1}};
   localparam logic [TRACE_BITS-1:0] TRACE_LAST = TRACE_BITS'(MAX_TRACES - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = COUNT_BITS'(MAX_TRACE_LEN);

   typedef struct packed {
      logic [SUM_BITS-1:0]   sum;
      logic [COUNT_BITS-1:0] count;
      logic                  last_trace;
   } trace_close_type;

endpackage

// File: src/rmse_front.sv
// Front end: take sample pairs, square the difference and accumulate per trace
`include "rms_error_accumulator_defines.svh"

module rmse_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [rmse_pkg::FIELD_BITS-1:0] req_model_sample,
   input  logic signed [rmse_pkg::FIELD_BITS-1:0] req_reference_sample,
   input  logic                              req_last_sample,
   input  logic                              req_last_trace,
   input  logic                              queue_full,
   output logic                              queue_push,
   output rmse_pkg::trace_close_type         queue_data
);

   logic                                 a_valid_ff;
   logic [rmse_pkg::SQ_BITS-1:0]         a_sq_ff;
   logic                                 a_last_s_ff;
   logic                                 a_last_t_ff;
   logic [rmse_pkg::SUM_BITS-1:0]        sum_ff;
   logic [rmse_pkg::COUNT_BITS-1:0]      count_ff;

   logic signed [rmse_pkg::SAMPLE_BITS-1:0] model_s;
   logic signed [rmse_pkg::SAMPLE_BITS-1:0] ref_s;
   logic signed [rmse_pkg::DIFF_BITS-1:0]   diff;
   logic signed [2*rmse_pkg::DIFF_BITS-1:0] prod;
   logic                                 a_stall;
   logic                                 accept;
   logic                                 consume;
   logic                                 take;
   logic [rmse_pkg::SUM_BITS:0]          sum_wide;
   logic [rmse_pkg::SUM_BITS-1:0]        sum_in;
   logic [rmse_pkg::COUNT_BITS-1:0]      count_in;

   assign model_s = req_model_sample[rmse_pkg::SAMPLE_BITS-1:0];
   assign ref_s   = req_reference_sample[rmse_pkg::SAMPLE_BITS-1:0];
   assign diff    = rmse_pkg::DIFF_BITS'(model_s) - rmse_pkg::DIFF_BITS'(ref_s);
   assign prod    = diff * diff;

   assign a_stall   = a_valid_ff && a_last_s_ff && queue_full;
   assign req_ready = !a_stall;
   assign accept    = req_valid && req_ready;
   assign consume   = a_valid_ff && !a_stall;

   assign take     = count_ff < rmse_pkg::COUNT_LIMIT;
   assign sum_wide = {1'b0, sum_ff} + (rmse_pkg::SUM_BITS + 1)'(a_sq_ff);

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (take) begin
         sum_in   = sum_wide[rmse_pkg::SUM_BITS] ? rmse_pkg::SUM_MAX
                                                 : sum_wide[rmse_pkg::SUM_BITS-1:0];
         count_in = count_ff + 1'b1;
      end
   end

   assign queue_push            = consume && a_last_s_ff;
   assign queue_data.sum        = sum_in;
   assign queue_data.count      = count_in;
   assign queue_data.last_trace = a_last_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!a_stall) begin
         a_valid_ff <= accept;
      end
      if (!a_stall) begin
         a_sq_ff     <= prod[rmse_pkg::SQ_BITS-1:0];
         a_last_s_ff <= req_last_sample;
         a_last_t_ff <= req_last_trace;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (consume) begin
         if (a_last_s_ff) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end else begin
            sum_ff   <= sum_in;
            count_ff <= count_in;
         end
      end
   end

   `RMSE_ASSERT_ALWAYS(count_in_range, clock, reset, count_ff <= rmse_pkg::COUNT_LIMIT, "sample count past limit")
   `RMSE_ASSERT_IMPLIES(push_has_count, clock, reset, queue_push, queue_data.count != '0, "trace closed with zero count")

endmodule

// File: src/rmse_fifo.sv
// Short queue of closed traces between front and back end
`include "rms_error_accumulator_defines.svh"

module rmse_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rmse_pkg::trace_close_type push_data,
   output logic                      full,
   input  logic                      pop,
   output rmse_pkg::trace_close_type pop_data,
   output logic                      empty
);

   rmse_pkg::trace_close_type          mem_ff [rmse_pkg::QUEUE_DEPTH];
   logic [rmse_pkg::QPTR_BITS-1:0]     wr_ptr_ff;
   logic [rmse_pkg::QPTR_BITS-1:0]     rd_ptr_ff;
   logic [rmse_pkg::QPTR_BITS:0]       fill_ff;

   assign full     = fill_ff == (rmse_pkg::QPTR_BITS + 1)'(rmse_pkg::QUEUE_DEPTH);
   assign empty    = fill_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 1'b1;
            2'b01:   fill_ff <= fill_ff - 1'b1;
            default: fill_ff <= fill_ff;
         endcase
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RMSE_ASSERT_ALWAYS(no_push_full, clock, reset, !(push && full), "push into full queue")
   `RMSE_ASSERT_ALWAYS(no_pop_empty, clock, reset, !(pop && empty), "pop from empty queue")

endmodule

// File: src/rmse_back.sv
// Back end: divide sum by count, take the floor root, keep the set total
`include "rms_error_accumulator_defines.svh"

module rmse_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  queue_empty,
   input  rmse_pkg::trace_close_type             queue_data,
   output logic                                  queue_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rmse_pkg::ERROR_BITS-1:0]       rsp_trace_error,
   output logic [rmse_pkg::TRACE_BITS-1:0]       rsp_trace_number,
   output logic [rmse_pkg::TOTAL_BITS-1:0]       rsp_set_total,
   output logic                                  rsp_set_done
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_ROOT,
      S_DONE
   } state_type;

   state_type                              state_ff;
   logic [rmse_pkg::STEP_BITS-1:0]         step_ff;
   logic [rmse_pkg::SUM_BITS-1:0]          work_ff;
   logic [rmse_pkg::COUNT_BITS-1:0]        div_ff;
   logic [rmse_pkg::COUNT_BITS:0]          rem_ff;
   logic [rmse_pkg::ROOT_BITS+2:0]         root_rem_ff;
   logic [rmse_pkg::ROOT_BITS-1:0]         root_ff;
   logic                                   last_t_ff;
   logic [rmse_pkg::TOTAL_BITS-1:0]        total_ff;
   logic [rmse_pkg::TRACE_BITS-1:0]        counter_ff;
   logic                                   rsp_valid_ff;
   logic [rmse_pkg::ERROR_BITS-1:0]        rsp_trace_error_ff;
   logic [rmse_pkg::TRACE_BITS-1:0]        rsp_trace_number_ff;
   logic [rmse_pkg::TOTAL_BITS-1:0]        rsp_set_total_ff;
   logic                                   rsp_set_done_ff;

   logic [rmse_pkg::COUNT_BITS:0]          div_trial;
   logic                                   div_fits;
   logic [rmse_pkg::ROOT_BITS+2:0]         root_shift;
   logic [rmse_pkg::ROOT_BITS+2:0]         root_trial;
   logic                                   root_fits;
   logic [rmse_pkg::ERROR_BITS-1:0]        err;
   logic [rmse_pkg::TOTAL_BITS:0]          total_wide;
   logic [rmse_pkg::TOTAL_BITS-1:0]        total_in;
   logic                                   out_free;

   assign div_trial = {rem_ff[rmse_pkg::COUNT_BITS-1:0], work_ff[rmse_pkg::SUM_BITS-1]};
   assign div_fits  = div_trial >= {1'b0, div_ff};

   assign root_shift = {root_rem_ff[rmse_pkg::ROOT_BITS:0],
                        work_ff[rmse_pkg::SUM_BITS-1 -: 2]};
   assign root_trial = (rmse_pkg::ROOT_BITS + 3)'({root_ff, 2'b01});
   assign root_fits  = root_shift >= root_trial;

   assign err = (root_ff[rmse_pkg::ROOT_BITS-1:rmse_pkg::ERROR_BITS] != '0)
              ? rmse_pkg::ERROR_MAX : root_ff[rmse_pkg::ERROR_BITS-1:0];
   assign total_wide = {1'b0, total_ff} + (rmse_pkg::TOTAL_BITS + 1)'(err);
   assign total_in   = total_wide[rmse_pkg::TOTAL_BITS] ? rmse_pkg::TOTAL_MAX
                                                        : total_wide[rmse_pkg::TOTAL_BITS-1:0];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign queue_pop = (state_ff == S_IDLE) && !queue_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (!queue_empty) begin
                  work_ff   <= queue_data.sum;
                  div_ff    <= queue_data.count;
                  last_t_ff <= queue_data.last_trace;
                  rem_ff    <= '0;
                  step_ff   <= rmse_pkg::STEP_BITS'(rmse_pkg::SUM_BITS - 1);
                  state_ff  <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff  <= div_fits ? div_trial - {1'b0, div_ff} : div_trial;
               work_ff <= {work_ff[rmse_pkg::SUM_BITS-2:0], div_fits};
               if (step_ff == '0) begin
                  root_rem_ff <= '0;
                  root_ff     <= '0;
                  step_ff     <= rmse_pkg::STEP_BITS'(rmse_pkg::ROOT_BITS - 1);
                  state_ff    <= S_ROOT;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            S_ROOT: begin
               root_rem_ff <= root_fits ? root_shift - root_trial : root_shift;
               root_ff     <= {root_ff[rmse_pkg::ROOT_BITS-2:0], root_fits};
               work_ff     <= {work_ff[rmse_pkg::SUM_BITS-3:0], 2'b00};
               step_ff     <= step_ff - 1'b1;
               if (step_ff == '0) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_trace_error_ff  <= err;
                  rsp_trace_number_ff <= counter_ff;
                  rsp_set_total_ff    <= total_in;
                  rsp_set_done_ff     <= last_t_ff;
                  if (last_t_ff) begin
                     total_ff   <= '0;
                     counter_ff <= '0;
                  end else begin
                     total_ff <= total_in;
                     if (counter_ff != rmse_pkg::TRACE_LAST) begin
                        counter_ff <= counter_ff + 1'b1;
                     end
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_trace_error  = rsp_trace_error_ff;
   assign rsp_trace_number = rsp_trace_number_ff;
   assign rsp_set_total    = rsp_set_total_ff;
   assign rsp_set_done     = rsp_set_done_ff;

   `RMSE_ASSERT_NEXT(pop_starts_divide, clock, reset, queue_pop,
      state_ff == S_DIV, "pop did not start divide")
   `RMSE_ASSERT_IMPLIES(divisor_nonzero, clock, reset, state_ff == S_DIV,
      div_ff != '0, "divide by zero count")

endmodule

// File: src/rms_error_accumulator.sv
// Top level of the rms error accumulator
// The block takes one sample pair per cycle. The front end squares the pair
// difference and adds it into a saturating 48-bit sum with a sample count; at
// the pair marked last_sample it hands the trace's sum and count to a four-entry
// queue. The back end works through one closed trace at a time: it loads the
// entry, runs a radix-2 divider and then a two-bit-per-step floor square root,
// and writes the result register. Sample pairs keep flowing at one per cycle
// while the queue has room; a run of short traces that fills it holds
// req_ready low until the back end frees an entry. Results appear on the rsp_
// channel in trace order.
module rms_error_accumulator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [rmse_pkg::FIELD_BITS-1:0] req_model_sample,
   input  logic signed [rmse_pkg::FIELD_BITS-1:0] req_reference_sample,
   input  logic                                  req_last_sample,
   input  logic                                  req_last_trace,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rmse_pkg::ERROR_BITS-1:0]       rsp_trace_error,
   output logic [rmse_pkg::TRACE_BITS-1:0]       rsp_trace_number,
   output logic [rmse_pkg::TOTAL_BITS-1:0]       rsp_set_total,
   output logic                                  rsp_set_done
);

   logic                      queue_push;
   logic                      queue_full;
   logic                      queue_pop;
   logic                      queue_empty;
   rmse_pkg::trace_close_type push_data;
   rmse_pkg::trace_close_type pop_data;

   rmse_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_model_sample     (req_model_sample),
      .req_reference_sample (req_reference_sample),
      .req_last_sample      (req_last_sample),
      .req_last_trace       (req_last_trace),
      .queue_full           (queue_full),
      .queue_push           (queue_push),
      .queue_data           (push_data)
   );

   rmse_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   rmse_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .queue_data       (pop_data),
      .queue_pop        (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_trace_error  (rsp_trace_error),
      .rsp_trace_number (rsp_trace_number),
      .rsp_set_total    (rsp_set_total),
      .rsp_set_done     (rsp_set_done)
   );

endmodule

// File: bench/rms_error_accumulator_test.sv
// Self-checking testbench for the rms error accumulator: random and directed sample-pair traces
`timescale 1ns / 1ps

module rms_error_accumulator_test;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 800;
   localparam int DRAIN_CYCLES = 400;
   localparam int PHASE_PAIRS = 300;

   typedef struct packed {
      logic signed [rmse_pkg::FIELD_BITS-1:0] model;
      logic signed [rmse_pkg::FIELD_BITS-1:0] reference;
      logic                                   last_sample;
      logic                                   last_trace;
   } sample_pair_type;

   typedef struct packed {
      logic [rmse_pkg::ERROR_BITS-1:0] trace_error;
      logic [rmse_pkg::TRACE_BITS-1:0] trace_number;
      logic [rmse_pkg::TOTAL_BITS-1:0] set_total;
      logic                            set_done;
   } trace_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [rmse_pkg::FIELD_BITS-1:0] req_model_sample = '0;
   logic signed [rmse_pkg::FIELD_BITS-1:0] req_reference_sample = '0;
   logic req_last_sample = 1'b0;
   logic req_last_trace = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [rmse_pkg::ERROR_BITS-1:0] rsp_trace_error;
   logic [rmse_pkg::TRACE_BITS-1:0] rsp_trace_number;
   logic [rmse_pkg::TOTAL_BITS-1:0] rsp_set_total;
   logic rsp_set_done;

   sample_pair_type  pending_pairs[$];
   trace_result_type expected_trace_errors[$];
   sample_pair_type  offered_pair;

   logic [rmse_pkg::SUM_BITS-1:0]   square_sum = '0;
   logic [rmse_pkg::COUNT_BITS-1:0] sample_count = '0;
   logic [rmse_pkg::TOTAL_BITS-1:0] running_total = '0;
   logic [rmse_pkg::TRACE_BITS-1:0] trace_index = '0;

   int pairs_queued = 0;
   int pairs_accepted = 0;
   int mismatches = 0;
   int send_idle_pct = 30;
   int recv_idle_pct = 66;
   int holds_requested = 0;
   int holds_served = 0;
   int hold_left = 0;
   int cycle_count = 0;

   rms_error_accumulator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_model_sample(req_model_sample),
      .req_reference_sample(req_reference_sample),
      .req_last_sample(req_last_sample),
      .req_last_trace(req_last_trace),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_trace_error(rsp_trace_error),
      .rsp_trace_number(rsp_trace_number),
      .rsp_set_total(rsp_set_total),
      .rsp_set_done(rsp_set_done)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void accumulate_pair(input sample_pair_type pair);
      longint signed diff;
      longint unsigned sq;
      longint unsigned quotient;
      longint unsigned root;
      longint unsigned trial;
      longint unsigned total;
      trace_result_type result;
      if (sample_count < rmse_pkg::COUNT_LIMIT) begin
         diff = longint'($signed(pair.model)) - longint'($signed(pair.reference));
         sq = diff * diff;
         if (sq > 64'(rmse_pkg::SUM_MAX - square_sum)) begin
            square_sum = rmse_pkg::SUM_MAX;
         end else begin
            square_sum = square_sum + rmse_pkg::SUM_BITS'(sq);
         end
         sample_count = sample_count + 1'b1;
      end
      if (!pair.last_sample) return;
      quotient = 64'(square_sum) / 64'(sample_count);
      root = 0;
      for (int b = rmse_pkg::ROOT_BITS - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= quotient) root = trial;
      end
      if (root > 64'(rmse_pkg::ERROR_MAX)) root = 64'(rmse_pkg::ERROR_MAX);
      total = 64'(running_total) + root;
      if (total > 64'(rmse_pkg::TOTAL_MAX)) total = 64'(rmse_pkg::TOTAL_MAX);
      running_total = rmse_pkg::TOTAL_BITS'(total);
      result.trace_error = rmse_pkg::ERROR_BITS'(root);
      result.trace_number = trace_index;
      result.set_total = running_total;
      result.set_done = pair.last_trace;
      expected_trace_errors = {expected_trace_errors, result};
      square_sum = '0;
      sample_count = '0;
      if (pair.last_trace) begin
         running_total = '0;
         trace_index = '0;
      end else if (trace_index != rmse_pkg::TRACE_LAST) begin
         trace_index = trace_index + 1'b1;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            accumulate_pair(offered_pair);
            pairs_accepted = pairs_accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_pair = pending_pairs.pop_front();
               req_valid <= 1'b1;
               req_model_sample <= offered_pair.model;
               req_reference_sample <= offered_pair.reference;
               req_last_sample <= offered_pair.last_sample;
               req_last_trace <= offered_pair.last_trace;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      trace_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_trace_errors.size() == 0) begin
               $display("%0t: expected no result beat, actual error %0d trace %0d total %0d done %0d",
                        $time, rsp_trace_error, rsp_trace_number, rsp_set_total,
                        rsp_set_done);
               mismatches = mismatches + 1;
            end else begin
               want = expected_trace_errors.pop_front();
               if (rsp_trace_error !== want.trace_error) begin
                  $display("%0t: trace_error expected %0d actual %0d",
                           $time, want.trace_error, rsp_trace_error);
                  mismatches = mismatches + 1;
               end
               if (rsp_trace_number !== want.trace_number) begin
                  $display("%0t: trace_number expected %0d actual %0d",
                           $time, want.trace_number, rsp_trace_number);
                  mismatches = mismatches + 1;
               end
               if (rsp_set_total !== want.set_total) begin
                  $display("%0t: set_total expected %0d actual %0d",
                           $time, want.set_total, rsp_set_total);
                  mismatches = mismatches + 1;
               end
               if (rsp_set_done !== want.set_done) begin
                  $display("%0t: set_done expected %0d actual %0d",
                           $time, want.set_done, rsp_set_done);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (holds_served != holds_requested) begin
            holds_served <= holds_requested;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic push_pair(input logic signed [rmse_pkg::FIELD_BITS-1:0] model,
                            input logic signed [rmse_pkg::FIELD_BITS-1:0] reference,
                            input logic last_sample, input logic last_trace);
      sample_pair_type pair;
      pair.model = model;
      pair.reference = reference;
      pair.last_sample = last_sample;
      pair.last_trace = last_trace;
      pending_pairs = {pending_pairs, pair};
      pairs_queued = pairs_queued + 1;
   endtask

   function automatic logic signed [rmse_pkg::FIELD_BITS-1:0] random_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) return 16'sh7fff;
      if (pick < 20) return 16'sh8000;
      if (pick < 25) return '0;
      return rmse_pkg::FIELD_BITS'($urandom);
   endfunction

   task automatic queue_random_sets(input int pair_budget);
      int traces;
      int len;
      int pick;
      while (pair_budget > 0) begin
         traces = $urandom_range(20, 1);
         for (int t = 0; t < traces; t++) begin
            pick = $urandom_range(99);
            if (pick < 70) len = $urandom_range(4, 1);
            else if (pick < 95) len = $urandom_range(40, 5);
            else len = $urandom_range(300, 41);
            for (int s = 0; s < len; s++) begin
               if (s == len - 1) begin
                  push_pair(random_sample(), random_sample(), 1'b1, t == traces - 1);
               end else begin
                  push_pair(random_sample(), random_sample(), 1'b0,
                            $urandom_range(7) == 0);
               end
            end
            pair_budget = pair_budget - len;
         end
      end
   endtask

   task automatic wait_accepted();
      while (pairs_accepted != pairs_queued) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      push_pair(16'sh7fff, 16'sh8000, 1'b1, 1'b1);
      push_pair(16'sh8000, 16'sh7fff, 1'b1, 1'b0);
      push_pair(16'sd0, 16'sd0, 1'b1, 1'b0);
      push_pair(16'sd100, 16'sd0, 1'b0, 1'b1);
      push_pair(-16'sd5, 16'sd7, 1'b0, 1'b1);
      push_pair(16'sd3, 16'sd0, 1'b1, 1'b1);
      // run past the trace index and total limits
      for (int i = 0; i < 18; i++) begin
         if (i % 2 == 0) push_pair(16'sh7fff, 16'sh8000, 1'b1, i == 17);
         else push_pair(16'sh8000, 16'sh7fff, 1'b1, i == 17);
      end
      queue_random_sets(PHASE_PAIRS);
      wait_accepted();

      send_idle_pct = 66;
      recv_idle_pct = 30;
      queue_random_sets(PHASE_PAIRS);
      wait_accepted();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      holds_requested = holds_requested + 1;
      queue_random_sets(PHASE_PAIRS);
      wait_accepted();

      while (expected_trace_errors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
